// File: rtl/core/krl_pkg.sv
`timescale 1ns / 1ps

package krl_pkg;

    // Sizes of the key store and the remap table.
    localparam int NUM_KEYS    = 256;
    localparam int NUM_BUTTONS = 8;

    // Fixed field widths of the ports.
    localparam int CODE_W     = 8;
    localparam int OUT_BTN_W  = 8;
    localparam int SLOT_OUT_W = 3;

    // Derived widths.
    localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int KEY_CW = $clog2(NUM_KEYS + 1);
    localparam int BTN_AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int EXT_W  = CODE_W + 1;

    // Physical key codes.
    localparam logic [CODE_W-1:0] CODE_F1    = 8'h3B;
    localparam logic [CODE_W-1:0] CODE_LEFT  = 8'hCB;
    localparam logic [CODE_W-1:0] CODE_RIGHT = 8'hCD;
    localparam logic [CODE_W-1:0] CODE_UP    = 8'hC8;
    localparam logic [CODE_W-1:0] CODE_DOWN  = 8'hD0;
    localparam logic [CODE_W-1:0] CODE_Z     = 8'h2C;
    localparam logic [CODE_W-1:0] CODE_X     = 8'h2D;
    localparam logic [CODE_W-1:0] CODE_A     = 8'h1E;
    localparam logic [CODE_W-1:0] CODE_S     = 8'h1F;

    // Frame sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOT,
        ST_HOTD,
        ST_BTN,
        ST_SCAN,
        ST_OUT
    } krl_state_t;

    // Write request into the key store.
    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
        logic              data;
    } krl_wr_t;

    // Read request into the key store.
    typedef struct packed {
        logic              en;
        logic [KEY_AW-1:0] addr;
    } krl_rd_t;

    // Default key code of a logical button slot.
    function automatic logic [CODE_W-1:0] default_code(input int unsigned idx);
        logic [CODE_W-1:0] code;
        case (idx)
            0:       code = CODE_LEFT;
            1:       code = CODE_RIGHT;
            2:       code = CODE_UP;
            3:       code = CODE_DOWN;
            4:       code = CODE_Z;
            5:       code = CODE_X;
            6:       code = CODE_A;
            7:       code = CODE_S;
            default: code = '0;
        endcase
        return code;
    endfunction

    // A key code names a key of the store only below NUM_KEYS.
    function automatic logic code_in_range(input logic [CODE_W-1:0] code);
        return {1'b0, code} < EXT_W'(NUM_KEYS);
    endfunction

endpackage

// File: rtl/core/key_remap_with_learn_mode.sv
`timescale 1ns / 1ps

// Key remapper with learn mode. A key event transfer updates the key-down store. A
// frame-end transfer is evaluated by a sequencer that reads the store through its
// single read port, one key per cycle. A normal frame reads the key of every button,
// a frame with a hotkey edge goes from the hotkey read straight to the result, and a
// learning frame scans keys in ascending order, stopping early at the first eligible
// pressed key. The input is not ready while a frame is evaluated. Key events are still
// taken while a result waits in the output register. The mode hotkey is written over
// the cfg channel, which is always ready, and must only be changed while the block is
// idle. No clearing pass runs after reset.
module key_remap_with_learn_mode (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [krl_pkg::CODE_W-1:0]  s_key_code,
    input  logic                        s_pressed,
    input  logic                        s_frame_end,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [krl_pkg::OUT_BTN_W-1:0]  m_buttons,
    output logic                        m_learn_active,
    output logic [krl_pkg::SLOT_OUT_W-1:0] m_next_slot,
    output logic                        m_assigned,
    output logic [krl_pkg::CODE_W-1:0]  m_assigned_key,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [krl_pkg::CODE_W-1:0]  cfg_data
);
    import krl_pkg::*;

    krl_state_t state_reg, state_next;

    logic [CODE_W-1:0]      hotkey_reg;
    logic [CODE_W-1:0]      table_reg [NUM_BUTTONS];
    logic [CODE_W-1:0]      table_next [NUM_BUTTONS];
    logic                   learning_reg, learning_next;
    logic [BTN_AW-1:0]      slot_reg, slot_next;
    logic                   hot_before_reg, hot_before_next;

    logic [KEY_CW-1:0]      cnt_reg, cnt_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [KEY_CW-1:0]      rd_idx_reg, rd_idx_next;
    logic                   rd_ok_reg, rd_ok_next;

    logic [NUM_BUTTONS-1:0] btn_acc_reg, btn_acc_next;
    logic                   asg_reg, asg_next;
    logic [CODE_W-1:0]      akey_reg, akey_next;

    logic                   m_valid_reg, m_valid_next;
    logic [OUT_BTN_W-1:0]   m_buttons_reg, m_buttons_next;
    logic                   m_learn_reg, m_learn_next;
    logic [SLOT_OUT_W-1:0]  m_slot_reg, m_slot_next;
    logic                   m_asg_reg, m_asg_next;
    logic [CODE_W-1:0]      m_akey_reg, m_akey_next;

    krl_wr_t                wr;
    krl_rd_t                rd;
    logic                   key_q;

    logic                   hot_now;
    logic                   hot_edge;
    logic                   used;
    logic [CODE_W-1:0]      btn_code;
    logic [CODE_W-1:0]      scan_code;

    // Key-down store.
    krl_key_store u_store (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr     (wr),
        .rd     (rd),
        .rd_down(key_q)
    );

    // Handshake outputs.
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Result register.
    assign m_valid        = m_valid_reg;
    assign m_buttons      = m_buttons_reg;
    assign m_learn_active = m_learn_reg;
    assign m_next_slot    = m_slot_reg;
    assign m_assigned     = m_asg_reg;
    assign m_assigned_key = m_akey_reg;

    // Shared terms for the hotkey edge, the button reads and the learning scan.
    assign hot_now   = key_q & rd_ok_reg;
    assign hot_edge  = hot_now & ~hot_before_reg;
    assign scan_code = CODE_W'(rd_idx_reg);
    assign btn_code  = table_reg[cnt_reg[BTN_AW-1:0]];

    // A key already given to a slot below the current one is skipped.
    always_comb begin
        used = 1'b0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if ((i < int'(slot_reg)) && (table_reg[i] == scan_code)) begin
                used = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hotkey_reg     <= CODE_F1;
            learning_reg   <= 1'b0;
            slot_reg       <= '0;
            hot_before_reg <= 1'b1;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                table_reg[i] <= default_code(i);
            end
        end else begin
            state_reg      <= state_next;
            learning_reg   <= learning_next;
            slot_reg       <= slot_next;
            hot_before_reg <= hot_before_next;
            rd_vld_reg     <= rd_vld_next;
            m_valid_reg    <= m_valid_next;
            table_reg      <= table_next;
            if (cfg_valid && cfg_ready) begin
                hotkey_reg <= cfg_data;
            end
        end
    end

    // Working and result payload.
    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        rd_idx_reg    <= rd_idx_next;
        rd_ok_reg     <= rd_ok_next;
        btn_acc_reg   <= btn_acc_next;
        asg_reg       <= asg_next;
        akey_reg      <= akey_next;
        m_buttons_reg <= m_buttons_next;
        m_learn_reg   <= m_learn_next;
        m_slot_reg    <= m_slot_next;
        m_asg_reg     <= m_asg_next;
        m_akey_reg    <= m_akey_next;
    end

    // Frame sequencer.
    always_comb begin
        state_next      = state_reg;
        table_next      = table_reg;
        learning_next   = learning_reg;
        slot_next       = slot_reg;
        hot_before_next = hot_before_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        rd_ok_next      = rd_ok_reg;
        btn_acc_next    = btn_acc_reg;
        asg_next        = asg_reg;
        akey_next       = akey_reg;
        m_valid_next    = m_valid_reg & ~m_ready;
        m_buttons_next  = m_buttons_reg;
        m_learn_next    = m_learn_reg;
        m_slot_next     = m_slot_reg;
        m_asg_next      = m_asg_reg;
        m_akey_next     = m_akey_reg;

        wr.en   = s_valid && s_ready && !s_frame_end && code_in_range(s_key_code);
        wr.addr = s_key_code[KEY_AW-1:0];
        wr.data = s_pressed;
        rd.en   = 1'b0;
        rd.addr = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_frame_end) begin
                    btn_acc_next = '0;
                    asg_next     = 1'b0;
                    akey_next    = '0;
                    state_next   = ST_HOT;
                end
            end

            // Read the hotkey's level.
            ST_HOT: begin
                rd.en      = 1'b1;
                rd.addr    = hotkey_reg[KEY_AW-1:0];
                rd_ok_next = code_in_range(hotkey_reg);
                state_next = ST_HOTD;
            end

            // Decide the mode from the hotkey edge.
            ST_HOTD: begin
                hot_before_next = hot_now;
                cnt_next        = '0;
                if (!learning_reg) begin
                    if (hot_edge) begin
                        learning_next = 1'b1;
                        slot_next     = '0;
                        state_next    = ST_OUT;
                    end else begin
                        state_next = ST_BTN;
                    end
                end else if (hot_edge) begin
                    learning_next = 1'b0;
                    state_next    = ST_OUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end

            // Read each button's key through the table, one read in flight.
            ST_BTN: begin
                if (cnt_reg < KEY_CW'(NUM_BUTTONS)) begin
                    rd.en       = 1'b1;
                    rd.addr     = btn_code[KEY_AW-1:0];
                    rd_ok_next  = code_in_range(btn_code);
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg;
                    cnt_next    = cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    btn_acc_next[rd_idx_reg[BTN_AW-1:0]] = key_q & rd_ok_reg;
                end
                if ((cnt_reg == KEY_CW'(NUM_BUTTONS)) && !rd_vld_reg) begin
                    state_next = ST_OUT;
                end
            end

            // Scan keys upward for the first eligible pressed key.
            ST_SCAN: begin
                if (rd_vld_reg && key_q && ({1'b0, scan_code} != {1'b0, hotkey_reg})
                        && !used) begin
                    table_next[slot_reg] = scan_code;
                    asg_next             = 1'b1;
                    akey_next            = scan_code;
                    if (slot_reg == BTN_AW'(NUM_BUTTONS - 1)) begin
                        learning_next = 1'b0;
                        slot_next     = '0;
                    end else begin
                        slot_next = slot_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end else if (cnt_reg < KEY_CW'(NUM_KEYS)) begin
                    rd.en       = 1'b1;
                    rd.addr     = cnt_reg[KEY_AW-1:0];
                    rd_vld_next = 1'b1;
                    rd_idx_next = cnt_reg;
                    cnt_next    = cnt_reg + 1'b1;
                end else if (!rd_vld_reg) begin
                    state_next = ST_OUT;
                end
            end

            // Load the result once the output register is free.
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_buttons_next = OUT_BTN_W'(btn_acc_reg);
                    m_learn_next   = learning_reg;
                    m_slot_next    = learning_reg ? SLOT_OUT_W'(slot_reg) : '0;
                    m_asg_next     = asg_reg;
                    m_akey_next    = akey_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/krl_ram.sv
`timescale 1ns / 1ps

module krl_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/krl_key_store.sv
`timescale 1ns / 1ps

module krl_key_store (
    input  logic             aclk,
    input  logic             aresetn,
    input  krl_pkg::krl_wr_t wr,
    input  krl_pkg::krl_rd_t rd,
    output logic             rd_down
);
    import krl_pkg::*;

    logic [NUM_KEYS-1:0] vld_reg;
    logic                vld_q_reg;
    logic                ram_q;

    // The key-down bits live in a RAM.
    krl_ram #(
        .WIDTH(1),
        .DEPTH(NUM_KEYS)
    ) u_ram (
        .aclk (aclk),
        .we   (wr.en),
        .waddr(wr.addr),
        .wdata(wr.data),
        .re   (rd.en),
        .raddr(rd.addr),
        .rdata(ram_q)
    );

    // A key never written since reset reads as released.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // The valid bit is read alongside the RAM so both arrive together.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            vld_q_reg <= vld_reg[rd.addr];
        end
    end

    assign rd_down = vld_q_reg & ram_q;

endmodule

// File: rtl/core/krl_checker.sv
`timescale 1ns / 1ps

module krl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [krl_pkg::CODE_W-1:0]     s_key_code,
    input logic                           s_pressed,
    input logic                           s_frame_end,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [krl_pkg::OUT_BTN_W-1:0]  m_buttons,
    input logic                           m_learn_active,
    input logic [krl_pkg::SLOT_OUT_W-1:0] m_next_slot,
    input logic                           m_assigned,
    input logic [krl_pkg::CODE_W-1:0]     m_assigned_key,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [krl_pkg::CODE_W-1:0]     cfg_data
);

    // A stalled result holds its buttons.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_buttons))
        else $error("result changed while stalled");

    // Buttons read zero whenever learn mode is active.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_learn_active |-> m_buttons == '0)
        else $error("buttons not forced to zero in learn mode");

    // The slot number only means something in learn mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_learn_active |-> m_next_slot == '0)
        else $error("next slot nonzero outside learn mode");

    // No assigned key is reported without an assignment.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_assigned |-> m_assigned_key == '0)
        else $error("assigned key without an assignment");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind key_remap_with_learn_mode krl_checker u_krl_checker (.*);

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import krl_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    // A learning frame may scan every key before it finishes.
    localparam int SETTLE_CYCLES = 300;

    localparam logic ITEM_KEY   = 1'b0;
    localparam logic ITEM_FRAME = 1'b1;
    localparam logic KEY_UP     = 1'b0;
    localparam logic KEY_DOWN   = 1'b1;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              pressed;
        logic              frame_end;
    } key_item_t;

    typedef struct packed {
        logic [OUT_BTN_W-1:0]  buttons;
        logic                  learn_active;
        logic [SLOT_OUT_W-1:0] next_slot;
        logic                  assigned;
        logic [CODE_W-1:0]     assigned_key;
    } frame_result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CODE_W-1:0]     s_key_code = '0;
    logic                  s_pressed = 1'b0;
    logic                  s_frame_end = 1'b0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_BTN_W-1:0]  m_buttons;
    logic                  m_learn_active;
    logic [SLOT_OUT_W-1:0] m_next_slot;
    logic                  m_assigned;
    logic [CODE_W-1:0]     m_assigned_key;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CODE_W-1:0]     cfg_data = '0;

    // Pending stimulus and the frame results still owed by the block.
    key_item_t     pending_items[$];
    frame_result_t expected_frames[$];
    int            queued_total = 0;
    int            accepted_total = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            s_took = 1'b0;
    bit            m_took = 1'b0;
    bit            calm = 1'b0;
    int            send_gap = 0;
    int            recv_stall = 0;
    key_item_t     next_item;

    // Shadow state of the remapper.
    logic              key_held [0:NUM_KEYS-1];
    logic [CODE_W-1:0] button_map [0:NUM_BUTTONS-1];
    logic              learn_on;
    logic [3:0]        learn_pos;
    logic              hotkey_seen;
    logic [CODE_W-1:0] hotkey_code;

    key_remap_with_learn_mode dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_key_code     (s_key_code),
        .s_pressed      (s_pressed),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_buttons      (m_buttons),
        .m_learn_active (m_learn_active),
        .m_next_slot    (m_next_slot),
        .m_assigned     (m_assigned),
        .m_assigned_key (m_assigned_key),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    task automatic clear_remap_state();
        for (int k = 0; k < NUM_KEYS; k++) key_held[k] = 1'b0;
        button_map[0] = CODE_LEFT;
        button_map[1] = CODE_RIGHT;
        button_map[2] = CODE_UP;
        button_map[3] = CODE_DOWN;
        button_map[4] = CODE_Z;
        button_map[5] = CODE_X;
        button_map[6] = CODE_A;
        button_map[7] = CODE_S;
        learn_on    = 1'b0;
        learn_pos   = '0;
        hotkey_seen = 1'b1;
        hotkey_code = CODE_F1;
    endtask

    // Applies one accepted item to the shadow state; a frame end owes one result.
    task automatic remap_key_item(input key_item_t it);
        frame_result_t res;
        logic          hot_now;
        logic          hot_edge;
        logic          found;
        logic          in_use;
        if (it.frame_end == ITEM_KEY) begin
            key_held[it.code] = it.pressed;
        end else begin
            res = '0;
            hot_now = key_held[hotkey_code];
            hot_edge = hot_now && !hotkey_seen;
            hotkey_seen = hot_now;
            if (!learn_on) begin
                for (int b = 0; b < NUM_BUTTONS; b++)
                    res.buttons[b] = key_held[button_map[b]];
                // A hotkey edge enters learn mode with the buttons forced low.
                if (hot_edge) begin
                    res.buttons = '0;
                    learn_on = 1'b1;
                    learn_pos = '0;
                end
            end else if (hot_edge) begin
                learn_on = 1'b0;
            end else begin
                // Lowest held key that is neither the hotkey nor already mapped.
                found = 1'b0;
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (!found && key_held[k] && k != hotkey_code) begin
                        in_use = 1'b0;
                        for (int b = 0; b < NUM_BUTTONS; b++)
                            if (b < learn_pos && button_map[b] == k) in_use = 1'b1;
                        if (!in_use) begin
                            found = 1'b1;
                            button_map[learn_pos[2:0]] = CODE_W'(k);
                            learn_pos = learn_pos + 1'b1;
                            res.assigned = 1'b1;
                            res.assigned_key = CODE_W'(k);
                            if (learn_pos >= NUM_BUTTONS) learn_on = 1'b0;
                        end
                    end
                end
            end
            res.learn_active = learn_on;
            res.next_slot = learn_on ? learn_pos[2:0] : '0;
            expected_frames.push_back(res);
        end
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Monitor and predictor: both act on the transfers of this rising edge.
    always @(posedge aclk) begin
        frame_result_t want;
        s_took = aresetn && s_valid && s_ready;
        m_took = aresetn && m_valid && m_ready;
        if (m_took) begin
            if (expected_frames.size() == 0) begin
                $error("frame result with no frame end pending: buttons %0h", m_buttons);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                check_field("buttons", want.buttons, m_buttons);
                check_field("learn_active", 8'(want.learn_active), 8'(m_learn_active));
                check_field("next_slot", 8'(want.next_slot), 8'(m_next_slot));
                check_field("assigned", 8'(want.assigned), 8'(m_assigned));
                check_field("assigned_key", want.assigned_key, m_assigned_key);
            end
        end
        if (s_took) begin
            remap_key_item({s_key_code, s_pressed, s_frame_end});
            accepted_total++;
        end
    end

    // Input driver: holds an item until its transfer, then waits out a drawn gap.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_took) begin
            s_valid <= 1'b1;
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            s_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            next_item = pending_items.pop_front();
            s_valid <= 1'b1;
            s_key_code <= next_item.code;
            s_pressed <= next_item.pressed;
            s_frame_end <= next_item.frame_end;
            send_gap = calm ? 0 : $urandom_range(0, 7);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Result receiver: stalls a drawn number of cycles before each transfer.
    always @(negedge aclk) begin
        if (m_took) recv_stall = calm ? 0 : $urandom_range(0, 7);
        else if (recv_stall > 0) recv_stall = recv_stall - 1;
        m_ready <= aresetn && (recv_stall == 0);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic push_key(input logic [CODE_W-1:0] code, input logic state);
        pending_items.push_back('{code, state, ITEM_KEY});
        queued_total++;
    endtask

    // The key fields of a frame end are ignored, so they carry noise.
    task automatic push_frame();
        pending_items.push_back('{CODE_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)), ITEM_FRAME});
        queued_total++;
    endtask

    // Mapped keys, the hotkey and the code extremes are favored.
    function automatic logic [CODE_W-1:0] pick_key(input logic [CODE_W-1:0] hot);
        logic [CODE_W-1:0] code;
        if ($urandom_range(0, 1)) begin
            code = CODE_W'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 13))
                0:       code = CODE_LEFT;
                1:       code = CODE_RIGHT;
                2:       code = CODE_UP;
                3:       code = CODE_DOWN;
                4:       code = CODE_Z;
                5:       code = CODE_X;
                6:       code = CODE_A;
                7:       code = CODE_S;
                8:       code = 8'h00;
                9:       code = 8'hFF;
                10:      code = 8'h01;
                11:      code = 8'h80;
                12:      code = 8'h7F;
                default: code = hot;
            endcase
        end
        return code;
    endfunction

    // A clean hotkey edge, then frames that each offer keys to learn.
    task automatic queue_learn_session(input logic [CODE_W-1:0] hot);
        int                slots;
        logic [CODE_W-1:0] first_key;
        push_key(hot, KEY_UP);
        push_frame();
        push_key(hot, KEY_DOWN);
        push_frame();
        if ($urandom_range(0, 1)) push_key(hot, KEY_UP);
        slots = $urandom_range(1, 9);
        for (int s = 0; s < slots; s++) begin
            first_key = pick_key(hot);
            push_key(first_key, KEY_DOWN);
            if ($urandom_range(0, 2) == 0) push_key(pick_key(hot), KEY_DOWN);
            push_frame();
            if ($urandom_range(0, 1)) push_key(first_key, KEY_UP);
        end
        // Sometimes leave early on a second hotkey edge.
        if ($urandom_range(0, 3) == 0) begin
            push_key(hot, KEY_UP);
            push_frame();
            push_key(hot, KEY_DOWN);
            push_frame();
            push_key(hot, KEY_UP);
        end
    endtask

    task automatic queue_random_phase(input logic [CODE_W-1:0] hot, input int count);
        int first;
        int events;
        first = queued_total;
        while (queued_total - first < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_learn_session(hot);
                4, 5, 6, 7: begin
                    events = $urandom_range(1, 4);
                    for (int e = 0; e < events; e++)
                        push_key(pick_key(hot), 1'($urandom_range(0, 1)));
                    push_frame();
                end
                default: begin
                    if ($urandom_range(0, 1)) push_frame();
                    else push_key(CODE_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)));
                end
            endcase
        end
    endtask

    // Waits until every item has gone in and every result has come out.
    task automatic wait_drained();
        while (!(accepted_total == queued_total && expected_frames.size() == 0))
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_hotkey(input logic [CODE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!(cfg_valid && cfg_ready)) @(posedge aclk);
        hotkey_code = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CODE_W-1:0] hot;
        clear_remap_state();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: default mapping, learn entry with the hotkey held, duplicate
        // and hotkey skipping, an idle learning frame, exit on a hotkey edge.
        push_frame();
        push_key(CODE_LEFT, KEY_DOWN);
        push_key(CODE_S, KEY_DOWN);
        push_frame();
        push_key(CODE_F1, KEY_DOWN);
        push_frame();
        push_key(8'h00, KEY_DOWN);
        push_frame();
        push_frame();
        push_frame();
        push_frame();
        push_key(CODE_F1, KEY_UP);
        push_frame();
        push_key(CODE_F1, KEY_DOWN);
        push_frame();
        push_key(CODE_F1, KEY_UP);
        push_key(8'hFF, KEY_DOWN);
        push_frame();
        push_key(8'h00, KEY_UP);
        push_key(8'hFF, KEY_UP);
        push_key(CODE_LEFT, KEY_UP);
        push_key(CODE_S, KEY_UP);
        push_frame();
        wait_drained();

        // Random phases, each under its own hotkey; the second runs without idling.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       hot = 8'h00;
                1:       hot = 8'hFF;
                2:       hot = CODE_F1;
                default: hot = CODE_W'($urandom_range(0, 255));
            endcase
            calm = (p == 1);
            write_hotkey(hot);
            queue_random_phase(hot, 225);
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/krl_pkg.sv
rtl/core/krl_ram.sv
rtl/core/krl_key_store.sv
rtl/core/key_remap_with_learn_mode.sv
rtl/core/krl_checker.sv
test/tb.sv
